[src/u8l9_pkg.sv]
`default_nettype none

package u8l9_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned AccW  = 24;
	localparam int unsigned RemW  = 2;

	localparam logic [ByteW-1:0] LeadMin2   = 8'hC0;
	localparam logic [ByteW-1:0] LeadMin3   = 8'hE0;
	localparam logic [ByteW-1:0] LeadMin4   = 8'hF0;
	localparam logic [ByteW-1:0] QMark      = 8'h3F;
	localparam logic [ByteW-1:0] EuroLatin9 = 8'hA4;
	localparam logic [AccW-1:0]  EuroCode   = 24'h0220AC;

	typedef struct packed {
		logic [ByteW-1:0] in_byte;
		logic             is_last;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             end_of_text;
	} out_item_t;

	// Outcome of one byte: whether a result goes out, the result, and the
	// sequence state left behind.
	typedef struct packed {
		logic            emit;
		out_item_t       item;
		logic [RemW-1:0] rem;
		logic [AccW-1:0] acc;
	} step_t;

	// Maps a completed code point onto Latin-9.
	function automatic logic [ByteW-1:0] map_value(input logic [AccW-1:0] v);
		logic [ByteW-1:0] r;
		if (v[AccW-1:ByteW] == '0) begin
			r = v[ByteW-1:0];
		end else if (v == EuroCode) begin
			r = EuroLatin9;
		end else begin
			r = QMark;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/utf8_to_latin9_decoder.sv]
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_item  (in_byte, is_last)
// out      output     out_valid / out_ready  out_item (out_byte, end_of_text)
//
// One byte is taken per cycle unless a full result register stalls the input
// register; its result, if any, moves from the input register to the result
// register once that register can take it, and is offered from there.
// Reset (arst_n low) closes any open sequence and empties both registers.
// While a result waits in the output register, the input register still
// takes one byte; the decode step then holds until the result is taken.
// Lead and middle bytes of a sequence produce no result unless marked last.

module utf8_to_latin9_decoder
	import u8l9_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	// Input register.
	logic     valid_s1;
	in_item_t item_s1;

	// Sequence state: bytes still expected and the bits gathered so far.
	logic [RemW-1:0] rem_q;
	logic [AccW-1:0] acc_q;

	// Result register.
	logic      out_valid_q;
	out_item_t out_item_q;

	logic  out_free;
	logic  advance;
	step_t nxt;

	// The decode step runs when the input register holds a byte and the result
	// register can take its outcome: empty, or being emptied in this cycle.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	u8l9_step u_step (
		.item (item_s1),
		.rem  (rem_q),
		.acc  (acc_q),
		.nxt  (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			acc_q <= '0;
		end else if (advance) begin
			rem_q <= nxt.rem;
			acc_q <= nxt.acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && nxt.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && nxt.emit) begin
			out_item_q <= nxt.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// The last byte of a text always leaves the decoder idle.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.is_last |=> rem_q == '0)
		else $error("sequence left open after last byte");

	// A plain byte outside a sequence comes out unchanged on the next edge.
	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rem_q == '0 && item_s1.in_byte < LeadMin2
		|=> out_valid_q && out_item_q.out_byte == $past(item_s1.in_byte))
		else $error("plain byte not passed through");

	// A byte held back by a full result register is not dropped.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("stalled input register lost its byte");

	// Every result that closes the text is taken from an item marked last.
	a_end_marked: assert property (@(posedge clk) disable iff (!arst_n)
		advance && nxt.emit && nxt.item.end_of_text |-> item_s1.is_last)
		else $error("end of text flagged on a byte not marked last");

endmodule

`default_nettype wire

[src/u8l9_step.sv]
`default_nettype none

module u8l9_step
	import u8l9_pkg::*;
(
	input  wire in_item_t        item,
	input  wire logic [RemW-1:0] rem,
	input  wire logic [AccW-1:0] acc,
	output step_t                nxt
);

	logic [AccW-1:0] acc_shift;
	logic [RemW-1:0] rem_dec;

	assign acc_shift = {acc[AccW-7:0], item.in_byte[5:0]};
	assign rem_dec   = rem - RemW'(1);

	always_comb begin
		nxt.emit        = 1'b0;
		nxt.item        = '{out_byte: QMark, end_of_text: item.is_last};
		nxt.rem         = rem;
		nxt.acc         = acc;
		if (rem == '0) begin
			if (item.in_byte < LeadMin2) begin
				// Plain byte outside any sequence passes through.
				nxt.emit          = 1'b1;
				nxt.item.out_byte = item.in_byte;
			end else begin
				nxt.acc = AccW'(item.in_byte[5:0]);
				if (item.in_byte >= LeadMin4) begin
					nxt.rem = RemW'(3);
				end else if (item.in_byte >= LeadMin3) begin
					nxt.rem = RemW'(2);
				end else begin
					nxt.rem = RemW'(1);
				end
			end
		end else begin
			nxt.acc = acc_shift;
			nxt.rem = rem_dec;
			if (rem_dec == '0) begin
				nxt.emit          = 1'b1;
				nxt.item.out_byte = map_value(acc_shift);
			end
		end
		// A sequence still open at the end of the text collapses to one '?'.
		if (!nxt.emit && item.is_last) begin
			nxt.emit             = 1'b1;
			nxt.item.out_byte    = QMark;
			nxt.item.end_of_text = 1'b1;
			nxt.rem              = '0;
			nxt.acc              = '0;
		end
	end

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

// Testbench for the UTF-8 to Latin-9 decoder.
//
// A scoreboard watches every byte the decoder accepts and keeps its own model
// of the open sequence: how many bytes are still due and the code point bits
// gathered so far. From that model it predicts each decoded character and
// queues it. Every result the decoder hands over is compared, field by field,
// with the oldest prediction.
//
// The stimulus starts with a short directed list that touches the corners of
// the decoding rules. It then runs random text in four phases with different
// amounts of sender idling and receiver back-pressure.
module testbench
	import u8l9_pkg::*;
();

	// Scoreboard: predicts the decoded stream from the accepted bytes and
	// checks the decoder's results against that prediction in order.
	class latin9_scoreboard;
		out_item_t   predicted_q[$];
		logic [1:0]  seq_left;
		logic [23:0] code_acc;
		int unsigned n_errors;
		int unsigned n_bytes;
		int unsigned n_results;
		int unsigned n_euro;
		int unsigned n_trunc;

		function new();
			seq_left  = '0;
			code_acc  = '0;
			n_errors  = 0;
			n_bytes   = 0;
			n_results = 0;
			n_euro    = 0;
			n_trunc   = 0;
		endfunction

		function int unsigned pending();
			return predicted_q.size();
		endfunction

		function logic [7:0] to_latin9(input logic [23:0] cp);
			if (cp < 24'h000100) begin
				return cp[7:0];
			end
			if (cp == EuroCode) begin
				n_euro++;
				return EuroLatin9;
			end
			return QMark;
		endfunction

		function void predict(input logic [7:0] ch, input logic eot);
			out_item_t e;
			e.out_byte    = ch;
			e.end_of_text = eot;
			predicted_q.push_back(e);
		endfunction

		// Called once for every byte the decoder accepts.
		function void note_byte(input in_item_t it);
			logic [7:0] b;
			b = it.in_byte;
			n_bytes++;
			if (seq_left == 2'd0) begin
				// No sequence open: plain bytes pass, lead bytes open one.
				if (b < LeadMin2) begin
					predict(b, it.is_last);
					return;
				end
				if (b >= LeadMin4) begin
					seq_left = 2'd3;
				end else if (b >= LeadMin3) begin
					seq_left = 2'd2;
				end else begin
					seq_left = 2'd1;
				end
				code_acc = {18'd0, b[5:0]};
			end else begin
				// Any byte counts as a continuation, lead-like or not.
				code_acc = {code_acc[17:0], b[5:0]};
				seq_left = seq_left - 2'd1;
				if (seq_left == 2'd0) begin
					predict(to_latin9(code_acc), it.is_last);
					return;
				end
			end
			// The text ended with a sequence still open.
			if (it.is_last) begin
				n_trunc++;
				predict(QMark, 1'b1);
				seq_left = '0;
				code_acc = '0;
			end
		endfunction

		// Called once for every result the decoder hands over.
		function void check_result(input out_item_t got);
			out_item_t e;
			n_results++;
			if (predicted_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, got byte %02h eot %0b",
					$time, got.out_byte, got.end_of_text);
				return;
			end
			e = predicted_q.pop_front();
			if (got.out_byte !== e.out_byte) begin
				n_errors++;
				$display("%0t: out_byte expected %02h, got %02h",
					$time, e.out_byte, got.out_byte);
			end
			if (got.end_of_text !== e.end_of_text) begin
				n_errors++;
				$display("%0t: end_of_text expected %0b, got %0b",
					$time, e.end_of_text, got.end_of_text);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	latin9_scoreboard sb;

	utf8_to_latin9_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	// Input monitor. Values read right after the edge are the ones the
	// decoder saw at that edge, since every driver updates through
	// nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.note_byte(in_item);
		end
	end

	// Output monitor and receiver. The handshake is checked with the ready
	// value that held at the edge, then a fresh ready is drawn for the next
	// cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_item);
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one item and returns at the edge where it is accepted. Valid
	// stays high on return, so a following item goes out back to back
	// unless the sender decides to idle first.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		in_item.in_byte <= b;
		in_item.is_last <= last;
		@(posedge clk);
		while (in_ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	// Holds the sender off until every predicted character has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// A byte that follows a lead. Mostly a proper continuation byte, but now
	// and then any byte at all, since the decoder does not check them.
	function automatic logic [7:0] tail_byte();
		if ($urandom_range(9) == 0) begin
			return 8'($urandom_range(255));
		end
		return 8'($urandom_range(8'hBF, 8'h80));
	endfunction

	// Random end-of-text marks, roughly one byte in sixteen. A mark inside a
	// sequence cuts it short, which exercises the truncation path.
	function automatic logic rand_last();
		return ($urandom_range(15) == 0);
	endfunction

	// Random text. Most of it is well-formed characters of every length with
	// random content, the rest is loose bytes that may land anywhere.
	task automatic send_random_text(input int unsigned n_items);
		int unsigned sent;
		int unsigned kind;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				send_byte(8'($urandom_range(8'hBF)), rand_last());
				sent += 1;
			end else if (kind < 45) begin
				send_byte(8'($urandom_range(8'hDF, 8'hC0)), rand_last());
				send_byte(tail_byte(), rand_last());
				sent += 2;
			end else if (kind < 53) begin
				// Two-byte characters that land in the Latin-1 range.
				send_byte(8'($urandom_range(8'hC3, 8'hC2)), rand_last());
				send_byte(tail_byte(), rand_last());
				sent += 2;
			end else if (kind < 66) begin
				send_byte(8'($urandom_range(8'hEF, 8'hE0)), rand_last());
				send_byte(tail_byte(), rand_last());
				send_byte(tail_byte(), rand_last());
				sent += 3;
			end else if (kind < 76) begin
				send_byte(8'($urandom_range(8'hFF, 8'hF0)), rand_last());
				send_byte(tail_byte(), rand_last());
				send_byte(tail_byte(), rand_last());
				send_byte(tail_byte(), rand_last());
				sent += 4;
			end else if (kind < 84) begin
				// The euro sign.
				send_byte(8'hE2, rand_last());
				send_byte(8'h82, rand_last());
				send_byte(8'hAC, rand_last());
				sent += 3;
			end else begin
				send_byte(8'($urandom_range(255)), rand_last());
				sent += 1;
			end
		end
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall,
			input int unsigned n_items);
		idle_pct  = idle;
		stall_pct = stall;
		send_random_text(n_items);
		drain_results();
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with no idling on either side.
		// Extremes of the pass-through range.
		send_byte(8'h00, 1'b0);
		send_byte(8'hBF, 1'b0);
		// Two-byte character in the Latin-1 range, and the smallest overlong
		// two-byte form.
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		// Euro sign, then an overlong three-byte zero.
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		// Four-byte character that Latin-9 cannot hold.
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		// Text that ends on a lone lead byte.
		send_byte(8'hC3, 1'b1);
		// Text that ends in the middle of a three-byte sequence.
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		// A lead-like byte inside a sequence counts only by its low six bits,
		// so this still decodes to the euro sign.
		send_byte(8'hE2, 1'b0);
		send_byte(8'hC2, 1'b0);
		send_byte(8'hEC, 1'b0);
		// A plain byte that closes the text.
		send_byte(8'h41, 1'b1);
		// A complete character that does not fit and closes the text.
		send_byte(8'hDF, 1'b0);
		send_byte(8'hBF, 1'b1);
		drain_results();

		// Random part, about 1300 items over four idling mixes.
		run_phase(0, 0, 325);
		run_phase(73, 0, 325);
		run_phase(0, 73, 325);
		run_phase(15, 15, 325);

		// Let any byte still inside the pipeline settle out.
		repeat (10) @(posedge clk);

		$display("Run covered %0d input bytes and %0d decoded characters.",
			sb.n_bytes, sb.n_results);
		$display("Among them %0d euro signs and %0d texts cut short mid-sequence.",
			sb.n_euro, sb.n_trunc);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule
